>>> design/lmtfs_pkg.sv
// Package for the line map floor-search table.
// Types, payload structs, codes and default sizes shared by all lmtfs modules.
package lmtfs_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int LINE_W          = 20;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_APPENDED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef logic [LINE_W-1:0] t_line;

    typedef struct packed {
        logic  op;
        t_line gen_lno;
        t_line src_lno;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        t_line      found_line;
    } t_out_item;

    // One table row: both lines live in the same memory word
    typedef struct packed {
        t_line gen_lno;
        t_line src_lno;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

endpackage

>>> design/lmtfs_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
// Depends on lmtfs_pkg for the entry type.
module lmtfs_mem #(
    parameter int DEPTH = lmtfs_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  lmtfs_pkg::t_entry  i_wr_data,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output lmtfs_pkg::t_entry  o_rd_data
);

    lmtfs_pkg::t_entry r_mem [DEPTH];
    lmtfs_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/lmtfs_ctrl.sv
// Sequencer for appends and the binary floor search over the table memory.
// Depends on lmtfs_pkg; drives lmtfs_mem and hands results to the top-level output register.
module lmtfs_ctrl #(
    parameter int DEPTH = lmtfs_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lmtfs_pkg::t_in_item   i_in_item,
    input  logic                  i_res_free,
    output logic                  o_res_valid,
    output lmtfs_pkg::t_out_item  o_res,
    output logic                  o_mem_wr_en,
    output logic [AW-1:0]         o_mem_wr_addr,
    output lmtfs_pkg::t_entry     o_mem_wr_data,
    output logic                  o_mem_rd_en,
    output logic [AW-1:0]         o_mem_rd_addr,
    input  lmtfs_pkg::t_entry     i_mem_rd_data
);

    lmtfs_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_lo, n_lo;
    logic [CW-1:0]        r_hi_p1, n_hi_p1;   // exclusive upper bound
    logic [AW-1:0]        r_mid, n_mid;
    lmtfs_pkg::t_line     r_query, n_query;
    logic                 r_hit, n_hit;
    lmtfs_pkg::t_line     r_line, n_line;
    logic [1:0]           r_status, n_status;

    logic                 in_xfer;
    logic                 cmp_le;
    logic [CW:0]          mid_sum;
    logic                 probe_go;
    logic                 is_full;

    assign in_xfer = i_in_valid && (r_state == lmtfs_pkg::S_IDLE);
    assign is_full = (r_count == CW'(DEPTH));
    assign cmp_le  = (i_mem_rd_data.gen_lno <= r_query);

    // Datapath: bounds update, next midpoint, result fields
    always_comb begin
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi_p1  = r_hi_p1;
        n_query  = r_query;
        n_hit    = r_hit;
        n_line   = r_line;
        n_status = r_status;
        unique case (r_state)
            lmtfs_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_query = i_in_item.gen_lno;
                    n_hit   = 1'b0;
                    n_line  = '0;
                    n_lo    = '0;
                    n_hi_p1 = r_count;
                    if (i_in_item.op == lmtfs_pkg::OP_APPEND) begin
                        if (is_full) begin
                            n_status = lmtfs_pkg::ST_FULL;
                        end else begin
                            n_status = lmtfs_pkg::ST_APPENDED;
                            n_count  = r_count + CW'(1);
                        end
                    end
                end
            end
            lmtfs_pkg::S_SEARCH: begin
                if (cmp_le) begin
                    n_hit  = 1'b1;
                    n_line = i_mem_rd_data.src_lno;
                    n_lo   = CW'(r_mid) + CW'(1);
                end else begin
                    n_hi_p1 = CW'(r_mid);
                end
            end
            lmtfs_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
        // midpoint of inclusive range [lo, hi_p1-1]; only used when lo < hi_p1
        mid_sum  = {1'b0, n_lo} + {1'b0, n_hi_p1} - (CW+1)'(1);
        n_mid    = mid_sum[AW:1];
        probe_go = (n_lo < n_hi_p1);
        if (r_state == lmtfs_pkg::S_SEARCH && !probe_go) begin
            n_status = n_hit ? lmtfs_pkg::ST_FOUND : lmtfs_pkg::ST_NOT_FOUND;
        end
        if (r_state == lmtfs_pkg::S_IDLE && in_xfer &&
            i_in_item.op == lmtfs_pkg::OP_LOOKUP && !probe_go) begin
            n_status = lmtfs_pkg::ST_NOT_FOUND;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmtfs_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_item.op == lmtfs_pkg::OP_LOOKUP && probe_go) begin
                        n_state = lmtfs_pkg::S_SEARCH;
                    end else begin
                        n_state = lmtfs_pkg::S_DONE;
                    end
                end
            end
            lmtfs_pkg::S_SEARCH: begin
                if (!probe_go) begin
                    n_state = lmtfs_pkg::S_DONE;
                end
            end
            lmtfs_pkg::S_DONE: begin
                if (i_res_free) begin
                    n_state = lmtfs_pkg::S_IDLE;
                end
            end
            default: n_state = lmtfs_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready    = (r_state == lmtfs_pkg::S_IDLE);
        o_mem_wr_en   = in_xfer && (i_in_item.op == lmtfs_pkg::OP_APPEND) && !is_full;
        o_mem_wr_addr = r_count[AW-1:0];
        o_mem_wr_data = '{gen_lno: i_in_item.gen_lno, src_lno: i_in_item.src_lno};
        o_mem_rd_addr = n_mid;
        o_mem_rd_en   = 1'b0;
        unique case (r_state)
            lmtfs_pkg::S_IDLE:
                o_mem_rd_en = in_xfer && (i_in_item.op == lmtfs_pkg::OP_LOOKUP) && probe_go;
            lmtfs_pkg::S_SEARCH:
                o_mem_rd_en = probe_go;
            lmtfs_pkg::S_DONE:
                o_mem_rd_en = 1'b0;
            default:
                o_mem_rd_en = 1'b0;
        endcase
        o_res_valid = (r_state == lmtfs_pkg::S_DONE) && i_res_free;
        o_res       = '{status: r_status, found_line: r_line};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmtfs_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi_p1  <= n_hi_p1;
        r_mid    <= n_mid;
        r_query  <= n_query;
        r_hit    <= n_hit;
        r_line   <= n_line;
        r_status <= n_status;
    end

endmodule

>>> design/line_map_table_floor_search_top.sv
// Line map table: appends (generated, source) line pairs and answers floor lookups.
// An append goes through the DONE state to the output register; a lookup first makes
// k <= clog2(count+1) probes in SEARCH, one table read per cycle through the single read
// port of the entry memory. A new item is taken only after the last result has left DONE.
// Reset (synchronous, active low) empties the table and the output register;
// table contents are not cleared, only entries below the count are ever read.
module line_map_table_floor_search_top #(
    parameter int TABLE_DEPTH = lmtfs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lmtfs_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lmtfs_pkg::t_out_item  o_out_item
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    lmtfs_pkg::t_entry     mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    lmtfs_pkg::t_entry     mem_rd_data;

    logic                  res_free;
    logic                  res_valid;
    lmtfs_pkg::t_out_item  res;

    logic                  r_out_valid;
    lmtfs_pkg::t_out_item  r_out_item;

    lmtfs_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    lmtfs_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_res_free    (res_free),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    // Output register frees up in the same cycle its transfer completes
    assign res_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> sim/tb_line_map_table_floor_search_top.sv
// Testbench for line_map_table_floor_search_top: appends and floor lookups, with a
// scoreboard class that keeps its own copy of the table and predicts each result.
// Depends on lmtfs_pkg and the line_map_table_floor_search_top RTL.
module tb_line_map_table_floor_search_top;

    localparam int N_ITEMS  = 1850;
    localparam int LINE_TOP = 2**lmtfs_pkg::LINE_W - 1;
    localparam int TAIL_CYC = 20;

    class floor_table_scoreboard;
        lmtfs_pkg::t_line     gen_store[lmtfs_pkg::TABLE_DEPTH_DEF];
        lmtfs_pkg::t_line     src_store[lmtfs_pkg::TABLE_DEPTH_DEF];
        int                   count;
        lmtfs_pkg::t_out_item expected_q[$];
        int                   errors;
        int                   n_seen;

        function new();
            count  = 0;
            errors = 0;
            n_seen = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH result %0d: %s", n_seen, msg);
            errors++;
        endtask

        // Accepted input: update the table copy and queue the expected result
        function void note_input(lmtfs_pkg::t_in_item item);
            lmtfs_pkg::t_out_item r;
            int                   lo;
            int                   hi;
            int                   mid;
            r.status     = lmtfs_pkg::ST_APPENDED;
            r.found_line = '0;
            if (item.op == lmtfs_pkg::OP_APPEND) begin
                if (count >= lmtfs_pkg::TABLE_DEPTH_DEF) begin
                    r.status = lmtfs_pkg::ST_FULL;
                end else begin
                    gen_store[count] = item.gen_lno;
                    src_store[count] = item.src_lno;
                    count++;
                end
            end else begin
                // same probe path as the hardware, even if entries are unsorted
                r.status = lmtfs_pkg::ST_NOT_FOUND;
                lo = 0;
                hi = count - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (gen_store[mid] <= item.gen_lno) begin
                        r.status     = lmtfs_pkg::ST_FOUND;
                        r.found_line = src_store[mid];
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        task check_result(lmtfs_pkg::t_out_item got);
            lmtfs_pkg::t_out_item want;
            n_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected transfer, status %0d line %h",
                                 got.status, got.found_line));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.found_line !== want.found_line)
                report($sformatf("found_line %h, want %h", got.found_line, want.found_line));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    lmtfs_pkg::t_in_item  in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    lmtfs_pkg::t_out_item out_item;

    bit                   in_calm = 1'b0;
    bit                   out_calm = 1'b0;
    lmtfs_pkg::t_line     stored_gens[$];

    floor_table_scoreboard table_sb = new();

    line_map_table_floor_search_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                table_sb.note_input(in_item);
            if (out_valid && out_ready)
                table_sb.check_result(out_item);
        end
    end

    // Idle cycles before the next transfer; occasional stretches with none at all
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(10);
    endfunction

    task automatic send_item(input logic op, input lmtfs_pkg::t_line gen,
                             input lmtfs_pkg::t_line src);
        int w;
        w = draw_wait(in_calm);
        if (w > 0) begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_item.op      <= op;
        in_item.gen_lno <= gen;
        in_item.src_lno <= src;
        do @(posedge clk); while (!in_ready);
        if (op == lmtfs_pkg::OP_APPEND && stored_gens.size() < lmtfs_pkg::TABLE_DEPTH_DEF)
            stored_gens.push_back(gen);
    endtask

    task automatic take_results();
        int w;
        forever begin
            w = draw_wait(out_calm);
            if (w > 0) begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    endtask

    initial begin
        int               next_gen;
        int               pick;
        int               sel;
        int               qi;
        lmtfs_pkg::t_line gen;
        next_gen = 'h400;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        fork
            take_results();
        join_none

        // empty table
        send_item(lmtfs_pkg::OP_LOOKUP, 20'h00000, 20'h00000);
        send_item(lmtfs_pkg::OP_LOOKUP, 20'hFFFFF, 20'hFFFFF);
        // single entry: below, exact, far above
        send_item(lmtfs_pkg::OP_APPEND, 20'h00010, 20'h00000);
        send_item(lmtfs_pkg::OP_LOOKUP, 20'h0000F, 20'h00000);
        send_item(lmtfs_pkg::OP_LOOKUP, 20'h00010, 20'h00000);
        send_item(lmtfs_pkg::OP_LOOKUP, 20'hFFFFF, 20'h00000);
        // duplicate generated line: the later entry wins
        send_item(lmtfs_pkg::OP_APPEND, 20'h00010, 20'hFFFFF);
        send_item(lmtfs_pkg::OP_LOOKUP, 20'h00010, 20'h00000);
        send_item(lmtfs_pkg::OP_APPEND, 20'h00400, 20'h55555);
        // out-of-order entry: the search may miss it
        send_item(lmtfs_pkg::OP_APPEND, 20'h00008, 20'hAAAAA);
        send_item(lmtfs_pkg::OP_LOOKUP, 20'h00009, 20'h00000);
        send_item(lmtfs_pkg::OP_LOOKUP, 20'h00400, 20'h00000);
        send_item(lmtfs_pkg::OP_LOOKUP, 20'h00500, 20'hFFFFF);
        send_item(lmtfs_pkg::OP_LOOKUP, 20'h003FF, 20'h12345);

        for (int n = 14; n < N_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                // mostly ascending appends; a few land out of order
                if ($urandom_range(99) < 4) begin
                    gen = lmtfs_pkg::t_line'($urandom());
                end else begin
                    next_gen = next_gen + int'($urandom_range(7000));
                    if (next_gen > LINE_TOP)
                        next_gen = LINE_TOP;
                    gen = lmtfs_pkg::t_line'(next_gen);
                end
                send_item(lmtfs_pkg::OP_APPEND, gen, lmtfs_pkg::t_line'($urandom()));
            end else begin
                sel = $urandom_range(9);
                if (sel < 4 && stored_gens.size() > 0) begin
                    qi = int'(stored_gens[$urandom_range(stored_gens.size() - 1)])
                         + int'($urandom_range(6)) - 3;
                end else if (sel < 7) begin
                    qi = int'($urandom_range(next_gen + 100));
                end else if (sel == 7) begin
                    qi = $urandom_range(1) ? LINE_TOP : 0;
                end else begin
                    qi = int'($urandom_range(LINE_TOP));
                end
                if (qi < 0)
                    qi = 0;
                if (qi > LINE_TOP)
                    qi = LINE_TOP;
                send_item(lmtfs_pkg::OP_LOOKUP, lmtfs_pkg::t_line'(qi),
                          lmtfs_pkg::t_line'($urandom()));
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (table_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        if (table_sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> line_map_table_floor_search_top.f
design/lmtfs_pkg.sv
design/lmtfs_mem.sv
design/lmtfs_ctrl.sv
design/line_map_table_floor_search_top.sv
sim/tb_line_map_table_floor_search_top.sv
